// ===== rtl/mplc_pkg.sv =====
// Shared constants for the moving point against line segment crossing pipeline.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package mplc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 32;

  // Parallel tolerance register.
  localparam int          EPS_W     = 16;
  localparam logic [15:0] EPS_RESET = 16'd66;

endpackage

`default_nettype wire

// ===== rtl/mplc_div_step.sv =====
// One registered step of the restoring divider that forms the crossing time.
// Depends on nothing but the clock enable and data handed in by the top level.
`default_nettype none

module mplc_div_step #(
  parameter int REM_W = 53,
  parameter int Q_W   = 17,
  parameter int SB_W  = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              en,
  input  wire              valid_in,
  input  wire [REM_W-1:0]  rem_in,
  input  wire [REM_W-1:0]  den_in,
  input  wire [Q_W-1:0]    q_in,
  input  wire [SB_W-1:0]   sb_in,
  output logic             valid_out,
  output logic [REM_W-1:0] rem_out,
  output logic [REM_W-1:0] den_out,
  output logic [Q_W-1:0]   q_out,
  output logic [SB_W-1:0]  sb_out
);

  logic             ge;
  logic [REM_W-1:0] diff;

  assign ge   = (rem_in >= den_in);
  assign diff = ge ? (rem_in - den_in) : rem_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  // The remainder after a step is below the divisor, so the shift cannot overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= {diff[REM_W-2:0], 1'b0};
      den_out <= den_in;
      q_out   <= {q_in[Q_W-2:0], ge};
      sb_out  <= sb_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/moving_point_line_crossing.sv =====
// Top level of the moving point against line segment crossing pipeline.
// Depends on mplc_pkg and mplc_div_step.
`default_nettype none

// Streaming crossing test: each input transaction carries a static segment
// (start, end, unit normal, unit direction) and the start and end of a moving
// point, all signed fixed point with FRAC_BITS fraction bits. The block solves
// n.(move_start + v*t) = n.line_start for t, with v = move_end - move_start,
// and reports a hit with t and the crossing point, or a miss with all result
// fields zero. A path counts as parallel when |n.v| is at most the configured
// epsilon. The pipeline accepts one transaction every cycle while the output
// is not stalled, and returns one result per input in order. A query passes
// FRAC_BITS + 9 register stages; the length is set by the restoring divider,
// one quotient bit per stage, plus four stages before it and four after it.
// Every stage advances together whenever the output register is empty or
// being drained, so back pressure stalls the whole pipeline without losing or
// repeating anything. The epsilon register may be written only while no
// transaction is in flight.
module moving_point_line_crossing #(
  parameter int FRAC_BITS  = mplc_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = mplc_pkg::COORD_BITS_DEF,
  localparam int VW     = FRAC_BITS + 2,
  localparam int IN_RAW = 8 * COORD_BITS + 4 * VW,
  localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = FRAC_BITS + 1 + 2 * COORD_BITS,
  localparam int OUT_W  = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst,
  // Configuration: parallel_epsilon.
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [mplc_pkg::EPS_W-1:0]    cfg_data,
  // Query stream.
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // From bit 0 up: line_start_x, line_start_y, line_end_x, line_end_y,
  // line_normal_x, line_normal_y, line_dir_x, line_dir_y, move_start_x,
  // move_start_y, move_end_x, move_end_y, zero fill.
  input  wire [IN_W-1:0]               s_tdata,
  // Result stream.
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // From bit 0 up: crossing_time, hit_x, hit_y, zero fill.
  output logic [OUT_W-1:0]             m_tdata,
  // hit.
  output logic                         m_tuser
);

  import mplc_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;          // differences of two coordinates
  localparam int PW    = VW + DW;         // one normal product
  localparam int SW    = PW + 1;          // sum of two normal products
  localparam int REM_W = SW + 1;          // divider remainder and divisor
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int EW    = VW + CW + 1;     // direction dot a coordinate pair
  localparam int TW    = DW + Q_W + 1;    // velocity times time
  localparam int NSTEP = FRAC_BITS + 1;
  localparam int SB_W  = 1 + 2 * DW + 2 * CW + 2 * VW + 2 * EW;

  logic en;
  logic [EPS_W-1:0] eps;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_valid) begin
      eps <= cfg_data;
    end
  end

  // Field unpacking.
  logic signed [CW-1:0] in_lsx, in_lsy, in_lex, in_ley, in_msx, in_msy, in_mex, in_mey;
  logic signed [VW-1:0] in_nx, in_ny, in_dx, in_dy;

  assign in_lsx = s_tdata[0*CW +: CW];
  assign in_lsy = s_tdata[1*CW +: CW];
  assign in_lex = s_tdata[2*CW +: CW];
  assign in_ley = s_tdata[3*CW +: CW];
  assign in_nx  = s_tdata[4*CW +: VW];
  assign in_ny  = s_tdata[4*CW + VW +: VW];
  assign in_dx  = s_tdata[4*CW + 2*VW +: VW];
  assign in_dy  = s_tdata[4*CW + 3*VW +: VW];
  assign in_msx = s_tdata[4*CW + 4*VW +: CW];
  assign in_msy = s_tdata[5*CW + 4*VW +: CW];
  assign in_mex = s_tdata[6*CW + 4*VW +: CW];
  assign in_mey = s_tdata[7*CW + 4*VW +: CW];

  // Stage A: register the query and form velocity and offset.
  logic                 a_v;
  logic signed [CW-1:0] a_lsx, a_lsy, a_lex, a_ley, a_msx, a_msy;
  logic signed [VW-1:0] a_nx, a_ny, a_dx, a_dy;
  logic signed [DW-1:0] a_vx, a_vy, a_wx, a_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lsx <= in_lsx;
      a_lsy <= in_lsy;
      a_lex <= in_lex;
      a_ley <= in_ley;
      a_msx <= in_msx;
      a_msy <= in_msy;
      a_nx  <= in_nx;
      a_ny  <= in_ny;
      a_dx  <= in_dx;
      a_dy  <= in_dy;
      a_vx  <= DW'(in_mex) - DW'(in_msx);
      a_vy  <= DW'(in_mey) - DW'(in_msy);
      a_wx  <= DW'(in_lsx) - DW'(in_msx);
      a_wy  <= DW'(in_lsy) - DW'(in_msy);
    end
  end

  // Stage B: the eight products of the dot products.
  logic                 b_v;
  logic signed [PW-1:0] b_nvx, b_nvy, b_nwx, b_nwy;
  logic signed [EW-1:0] b_d1x, b_d1y, b_d2x, b_d2y;
  logic signed [DW-1:0] b_vx, b_vy;
  logic signed [CW-1:0] b_msx, b_msy;
  logic signed [VW-1:0] b_dx, b_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_nvx <= PW'(a_nx * a_vx);
      b_nvy <= PW'(a_ny * a_vy);
      b_nwx <= PW'(a_nx * a_wx);
      b_nwy <= PW'(a_ny * a_wy);
      b_d1x <= EW'(a_dx * a_lsx);
      b_d1y <= EW'(a_dy * a_lsy);
      b_d2x <= EW'(a_dx * a_lex);
      b_d2y <= EW'(a_dy * a_ley);
      b_vx  <= a_vx;
      b_vy  <= a_vy;
      b_msx <= a_msx;
      b_msy <= a_msy;
      b_dx  <= a_dx;
      b_dy  <= a_dy;
    end
  end

  // Stage C: sums.
  logic                 c_v;
  logic signed [SW-1:0] c_den, c_num;
  logic signed [EW-1:0] c_d1, c_d2;
  logic signed [DW-1:0] c_vx, c_vy;
  logic signed [CW-1:0] c_msx, c_msy;
  logic signed [VW-1:0] c_dx, c_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_den <= SW'(b_nvx) + SW'(b_nvy);
      c_num <= SW'(b_nwx) + SW'(b_nwy);
      c_d1  <= b_d1x + b_d1y;
      c_d2  <= b_d2x + b_d2y;
      c_vx  <= b_vx;
      c_vy  <= b_vy;
      c_msx <= b_msx;
      c_msy <= b_msy;
      c_dx  <= b_dx;
      c_dy  <= b_dy;
    end
  end

  // Stage D: fold the sign of the denominator into the numerator and decide
  // the parallel and out-of-range misses.
  logic signed [REM_W-1:0] den_w, num_w, den_abs, num_n;
  logic [REM_W-1:0]        lim;
  logic                    d_miss_next;

  assign den_w   = REM_W'(c_den);
  assign num_w   = REM_W'(c_num);
  assign den_abs = den_w[REM_W-1] ? -den_w : den_w;
  assign num_n   = den_w[REM_W-1] ? -num_w : num_w;
  assign lim     = REM_W'({eps, FRAC_BITS'(0)});
  assign d_miss_next = ($unsigned(den_abs) <= lim) || num_n[REM_W-1] ||
                       (num_n > den_abs);

  logic             d_v;
  logic [REM_W-1:0] d_rem, d_den;
  logic [SB_W-1:0]  d_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rem <= d_miss_next ? '0 : $unsigned(num_n);
      d_den <= d_miss_next ? REM_W'(1) : $unsigned(den_abs);
      d_sb  <= {d_miss_next, c_vx, c_vy, c_msx, c_msy, c_dx, c_dy, c_d1, c_d2};
    end
  end

  // Divider: one quotient bit per stage.
  logic             dv_v   [NSTEP+1];
  logic [REM_W-1:0] dv_rem [NSTEP+1];
  logic [REM_W-1:0] dv_den [NSTEP+1];
  logic [Q_W-1:0]   dv_q   [NSTEP+1];
  logic [SB_W-1:0]  dv_sb  [NSTEP+1];

  assign dv_v[0]   = d_v;
  assign dv_rem[0] = d_rem;
  assign dv_den[0] = d_den;
  assign dv_q[0]   = '0;
  assign dv_sb[0]  = d_sb;

  for (genvar g = 0; g < NSTEP; g++) begin : g_div
    mplc_div_step #(
      .REM_W (REM_W),
      .Q_W   (Q_W),
      .SB_W  (SB_W)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (dv_v[g]),
      .rem_in    (dv_rem[g]),
      .den_in    (dv_den[g]),
      .q_in      (dv_q[g]),
      .sb_in     (dv_sb[g]),
      .valid_out (dv_v[g+1]),
      .rem_out   (dv_rem[g+1]),
      .den_out   (dv_den[g+1]),
      .q_out     (dv_q[g+1]),
      .sb_out    (dv_sb[g+1])
    );
  end

  logic                 q_miss;
  logic signed [DW-1:0] q_vx, q_vy;
  logic signed [CW-1:0] q_msx, q_msy;
  logic signed [VW-1:0] q_dx, q_dy;
  logic signed [EW-1:0] q_d1, q_d2;

  assign {q_miss, q_vx, q_vy, q_msx, q_msy, q_dx, q_dy, q_d1, q_d2} = dv_sb[NSTEP];

  // Stage E: velocity times time.
  logic                 e_v, e_miss;
  logic signed [TW-1:0] e_tx, e_ty;
  logic [Q_W-1:0]       e_q;
  logic signed [CW-1:0] e_msx, e_msy;
  logic signed [VW-1:0] e_dx, e_dy;
  logic signed [EW-1:0] e_d1, e_d2;
  logic signed [Q_W:0]  q_s;

  assign q_s = $signed({1'b0, dv_q[NSTEP]});

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= dv_v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_tx   <= TW'(q_vx * q_s);
      e_ty   <= TW'(q_vy * q_s);
      e_q    <= dv_q[NSTEP];
      e_miss <= q_miss;
      e_msx  <= q_msx;
      e_msy  <= q_msy;
      e_dx   <= q_dx;
      e_dy   <= q_dy;
      e_d1   <= q_d1;
      e_d2   <= q_d2;
    end
  end

  // Stage F: round to the coordinate grid and add the start point. The point
  // lies between the path's ends, so it fits the coordinate width.
  logic signed [TW-1:0] rx, ry;

  assign rx = (e_tx + TW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign ry = (e_ty + TW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;

  logic                 f_v, f_miss;
  logic signed [CW-1:0] f_px, f_py;
  logic [Q_W-1:0]       f_q;
  logic signed [VW-1:0] f_dx, f_dy;
  logic signed [EW-1:0] f_d1, f_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_px   <= rx[CW-1:0] + e_msx;
      f_py   <= ry[CW-1:0] + e_msy;
      f_q    <= e_q;
      f_miss <= e_miss;
      f_dx   <= e_dx;
      f_dy   <= e_dy;
      f_d1   <= e_d1;
      f_d2   <= e_d2;
    end
  end

  // Stage G: project the crossing point on the segment direction.
  logic                   g_v, g_miss;
  logic signed [EW-2:0]   g_ppx, g_ppy;
  logic signed [CW-1:0]   g_px, g_py;
  logic [Q_W-1:0]         g_q;
  logic signed [EW-1:0]   g_d1, g_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_ppx  <= (EW-1)'(f_dx * f_px);
      g_ppy  <= (EW-1)'(f_dy * f_py);
      g_px   <= f_px;
      g_py   <= f_py;
      g_q    <= f_q;
      g_miss <= f_miss;
      g_d1   <= f_d1;
      g_d2   <= f_d2;
    end
  end

  // Stage H: extent test and the output register.
  logic signed [EW-1:0] dp;
  logic                 lo1, hi1, lo2, hi2, in_extent, hit_next;

  assign dp        = EW'(g_ppx) + EW'(g_ppy);
  assign lo1       = g_d1 < dp;
  assign hi1       = g_d1 > dp;
  assign lo2       = g_d2 < dp;
  assign hi2       = g_d2 > dp;
  assign in_extent = !((lo1 && lo2) || (hi1 && hi2));
  assign hit_next  = !g_miss && in_extent;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= hit_next;
      m_tdata <= hit_next ? OUT_W'({g_py, g_px, g_q}) : '0;
    end
  end

`ifndef SYNTHESIS
  // A miss carries no time and no point.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("miss result carries nonzero fields");

  // The crossing time never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[Q_W-1:0] <= Q_W'(1 << FRAC_BITS)))
    else $error("crossing time above one");

  // A stalled output register stalls the whole pipeline.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(g_v) && $stable(dv_v[NSTEP])))
    else $error("pipeline moved while the output was stalled");

  // A parallel or out-of-range query leaves the divider with a zero quotient.
  assert property (@(posedge clk) disable iff (rst)
    (dv_v[NSTEP] && q_miss) |-> (dv_q[NSTEP] == '0))
    else $error("missed query produced a quotient");
`endif

endmodule

`default_nettype wire

// ===== verif/moving_point_line_crossing_tb.sv =====
// Self-checking testbench for the moving point against line segment crossing block.
// Depends on mplc_pkg and the moving_point_line_crossing RTL; it reads no files.
`timescale 1ns / 100ps

module moving_point_line_crossing_tb;

  import mplc_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int CW    = COORD_BITS_DEF;
  localparam int VW    = FRAC + 2;
  localparam int IN_W  = ((8 * CW + 4 * VW + 7) / 8) * 8;
  localparam int OUT_W = ((FRAC + 1 + 2 * CW + 7) / 8) * 8;
  localparam int ONE   = 1 << FRAC;
  localparam int LATENCY     = FRAC + 12;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_ITEMS = 1600;

  // One crossing query, fields in the order they are packed on the bus.
  typedef struct {
    logic signed [CW-1:0] lsx, lsy, lex, ley;
    logic signed [VW-1:0] nx, ny, dx, dy;
    logic signed [CW-1:0] msx, msy, mex, mey;
  } query_t;

  typedef struct {
    logic                 hit;
    logic [FRAC:0]        t;
    logic [CW-1:0]        hx, hy;
  } crossing_t;

  // Holds the expected crossings in order and checks each returned result.
  class crossing_scoreboard;
    crossing_t        pending[$];
    logic [EPS_W-1:0] eps;
    int               fails;

    function new();
      eps   = EPS_RESET;
      fails = 0;
    endfunction

    // Exact crossing arithmetic at 128 bits, then the segment extent test.
    function crossing_t predict(query_t q);
      logic signed [127:0] nx, ny, dx, dy, vx, vy, den, num, lim, tq, px, py, dp, d1, d2;
      crossing_t r;
      r = '{hit: 1'b0, t: '0, hx: '0, hy: '0};
      nx = q.nx; ny = q.ny; dx = q.dx; dy = q.dy;
      vx = q.mex; vx = vx - q.msx;
      vy = q.mey; vy = vy - q.msy;
      px = q.lsx; px = px - q.msx;
      py = q.lsy; py = py - q.msy;
      den = nx * vx + ny * vy;
      num = nx * px + ny * py;
      lim = {96'b0, eps, 16'b0};
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      // Nearly parallel paths, and crossings outside 0..1, are misses.
      if (den <= lim || num < 0 || num > den) return r;
      tq = (num <<< FRAC) / den;
      px = ((vx * tq + (1 << (FRAC - 1))) >>> FRAC);
      px = px + q.msx;
      py = ((vy * tq + (1 << (FRAC - 1))) >>> FRAC);
      py = py + q.msy;
      dp = dx * px + dy * py;
      d1 = q.lsx; d1 = d1 * dx;
      d2 = q.lsy; d1 = d1 + d2 * dy;
      d2 = q.lex; d2 = d2 * dx;
      vx = q.ley; d2 = d2 + vx * dy;
      // Beyond both ends on the same side means the segment is missed.
      if ((d1 < dp && d2 < dp) || (d1 > dp && d2 > dp)) return r;
      r.hit = 1'b1;
      r.t   = tq[FRAC:0];
      r.hx  = px[CW-1:0];
      r.hy  = py[CW-1:0];
      return r;
    endfunction

    function void note_query(query_t q);
      pending.push_back(predict(q));
    endfunction

    function void check_result(logic user, logic [OUT_W-1:0] data);
      crossing_t e;
      if (pending.size() == 0) begin
        $error("result transaction with no query outstanding");
        fails++;
        return;
      end
      e = pending.pop_front();
      if (user !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, user);
        fails++;
      end
      if (data[FRAC:0] !== e.t) begin
        $error("crossing_time: expected %0h, got %0h", e.t, data[FRAC:0]);
        fails++;
      end
      if (data[FRAC+CW:FRAC+1] !== e.hx) begin
        $error("hit_x: expected %0h, got %0h", e.hx, data[FRAC+CW:FRAC+1]);
        fails++;
      end
      if (data[FRAC+2*CW:FRAC+CW+1] !== e.hy) begin
        $error("hit_y: expected %0h, got %0h", e.hy, data[FRAC+2*CW:FRAC+CW+1]);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [EPS_W-1:0]   cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tuser;

  crossing_scoreboard sb = new();
  int                 cycles = 0;
  bit                 burst_in = 1'b0;
  bit                 burst_out = 1'b0;

  moving_point_line_crossing dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one; bursts have none.
  function automatic int gap_length(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [IN_W-1:0] pack_query(query_t q);
    return {q.mey, q.mex, q.msy, q.msx, q.dy, q.dx, q.ny, q.nx,
            q.ley, q.lex, q.lsy, q.lsx};
  endfunction

  // Drives one query and waits for its transaction; valid stays high for a
  // following query when no gap is drawn.
  task automatic send_query(query_t q);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= pack_query(q);
    do @(posedge clk); while (!s_tready);
    sb.note_query(q);
    gap = gap_length(burst_in);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets the pipeline drain so nothing is in flight.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [EPS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.eps = value;
  endtask

  // Result side: check each transaction, then draw the next ready level.
  // Ready drops for gaps of the same mix of lengths as the sender uses.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if ($urandom_range(0, 199) == 0) burst_out = ~burst_out;
      if (burst_out) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = gap_length(1'b0);
        m_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("moving_point_line_crossing verification failed");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] rand_coord();
    return $urandom();
  endfunction

  function automatic logic signed [VW-1:0] rand_vec();
    return VW'($signed($urandom_range(0, 2 * ONE)) - ONE);
  endfunction

  // A well formed query: unit direction at a random angle, matching normal,
  // and a path that starts and ends near the segment, mostly crossing it.
  function automatic query_t shaped_query();
    query_t q;
    real    ang, len;
    int     span;
    ang  = $urandom_range(0, 62831) / 10000.0;
    span = ($urandom_range(0, 9) == 0) ? 1 << 28 : 1 << 21;
    q.dx = VW'($rtoi($cos(ang) * ONE));
    q.dy = VW'($rtoi($sin(ang) * ONE));
    q.nx = -q.dy;
    q.ny = q.dx;
    if ($urandom_range(0, 1)) begin
      q.nx = -q.nx;
      q.ny = -q.ny;
    end
    q.lsx = $signed($urandom_range(0, 2 * span)) - span;
    q.lsy = $signed($urandom_range(0, 2 * span)) - span;
    len   = $urandom_range(1, span) / real'(ONE);
    q.lex = q.lsx + $rtoi(q.dx * len);
    q.ley = q.lsy + $rtoi(q.dy * len);
    q.msx = q.lsx + $signed($urandom_range(0, 2 * span)) - span;
    q.msy = q.lsy + $signed($urandom_range(0, 2 * span)) - span;
    q.mex = q.lsx + $signed($urandom_range(0, 2 * span)) - span;
    q.mey = q.lsy + $signed($urandom_range(0, 2 * span)) - span;
    // Occasionally make the path run along the line.
    if ($urandom_range(0, 19) == 0) begin
      q.mex = q.msx + $rtoi(q.dx * len);
      q.mey = q.msy + $rtoi(q.dy * len);
    end
    return q;
  endfunction

  function automatic query_t noise_query();
    query_t q;
    q.lsx = rand_coord(); q.lsy = rand_coord();
    q.lex = rand_coord(); q.ley = rand_coord();
    q.nx = ($urandom_range(0, 3) == 0) ? VW'($urandom()) : rand_vec();
    q.ny = ($urandom_range(0, 3) == 0) ? VW'($urandom()) : rand_vec();
    q.dx = ($urandom_range(0, 3) == 0) ? VW'($urandom()) : rand_vec();
    q.dy = ($urandom_range(0, 3) == 0) ? VW'($urandom()) : rand_vec();
    q.msx = rand_coord(); q.msy = rand_coord();
    q.mex = rand_coord(); q.mey = rand_coord();
    return q;
  endfunction

  function automatic query_t axis_query(int lsx, int lsy, int lex, int ley,
                                        int nx, int ny, int dx, int dy,
                                        int msx, int msy, int mex, int mey);
    query_t q;
    q.lsx = lsx; q.lsy = lsy; q.lex = lex; q.ley = ley;
    q.nx = VW'(nx); q.ny = VW'(ny); q.dx = VW'(dx); q.dy = VW'(dy);
    q.msx = msx; q.msy = msy; q.mex = mex; q.mey = mey;
    return q;
  endfunction

  task automatic directed_queries();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // Horizontal segment from x = 0 to 4 at y = 0, path falling through it.
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, ONE, ONE, ONE, -ONE));
    // Crossing exactly at the start of the path and exactly at its end.
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, -ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, ONE, ONE, ONE, 0));
    // Crossing exactly on each end of the segment, then just beyond each.
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 0, ONE, 0, -ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 4 * ONE, ONE,
                          4 * ONE, -ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, -ONE, ONE, -ONE, -ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 5 * ONE, ONE,
                          5 * ONE, -ONE));
    // Crossing before and after the path, and a negative normal.
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, ONE, 3 * ONE, ONE, ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, ONE, -ONE, ONE, -3 * ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, -ONE, -ONE, 0, ONE, -ONE, 2 * ONE, ONE));
    // Parallel path, zero velocity, and a slope just either side of epsilon.
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 0, ONE, 4 * ONE, ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, ONE, ONE, ONE, ONE));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 0, 33, 4 * ONE, -33));
    send_query(axis_query(0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 0, 34, 4 * ONE, -33));
    // Vertical segment, non unit normal, and diagonal directions.
    send_query(axis_query(0, 0, 0, 4 * ONE, ONE, 0, 0, ONE, -ONE, ONE, ONE, 2 * ONE));
    send_query(axis_query(0, 0, 0, 4 * ONE, 2 * ONE - 1, 0, 0, -ONE, -ONE, ONE,
                          ONE, 3 * ONE));
    send_query(axis_query(0, 0, 46341, 46341, -46341, 46341, 46341, 46341,
                          ONE, 0, 0, ONE));
    // Coordinate and vector extremes.
    send_query(axis_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(axis_query(mn, 0, mx, 0, 0, ONE, ONE, 0, 0, mx, 0, mn));
    send_query(axis_query(mx, mx, mx, mx, ONE, ONE, ONE, ONE, mn, mn, mx, mx));
    send_query(axis_query(mn, mn, mn, mn, -ONE, -ONE, -ONE, -ONE, mx, mx, mn, mn));
    send_query(axis_query(mx, mn, mn, mx, -ONE, ONE, ONE, -ONE, mx, mx, mn, mn));
    send_query(axis_query(-1, -1, -1, -1, 131071, -131072, -131072, 131071,
                          mn, mx, mx, mn));
  endtask

  task automatic random_queries(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 149) == 0) burst_in = ~burst_in;
      if (i == count / 2) wait_drained();
      if ($urandom_range(0, 99) < 75) send_query(shaped_query());
      else send_query(noise_query());
    end
  endtask

  initial begin
    logic [EPS_W-1:0] eps_set[5];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // First phase runs with the reset epsilon, then the register is written.
    directed_queries();
    random_queries(RANDOM_ITEMS / 6);
    eps_set = '{16'd0, 16'hffff, 16'd1, 16'd66, 16'h0000};
    eps_set[4] = EPS_W'($urandom_range(0, 16'hffff));
    foreach (eps_set[k]) begin
      wait_drained();
      write_epsilon(eps_set[k]);
      @(posedge clk);
      if (k < 2) directed_queries();
      random_queries(RANDOM_ITEMS / 6);
    end
    wait_drained();
    repeat (LATENCY * 2) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("moving_point_line_crossing verification clean");
    end else begin
      $display("moving_point_line_crossing verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mplc_pkg.sv
rtl/mplc_div_step.sv
rtl/moving_point_line_crossing.sv
verif/moving_point_line_crossing_tb.sv
